// File: rtl/core/sdrv_pkg.sv
// Shared types, constants and the coil lookup for the half-step stepper driver.
`default_nettype none

package sdrv_pkg;

	localparam int unsigned SPEED_W  = 5;
	localparam int unsigned PHASE_W  = 3;
	localparam int unsigned TICK_W   = 16;
	localparam int unsigned BASE_W   = 16;
	localparam int unsigned DEC_W    = 13;
	localparam int unsigned MAG_W    = 4;
	localparam int unsigned KEY_W    = 8;
	localparam int unsigned COIL_W   = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned OUT_W    = 32;

	localparam logic signed [SPEED_W-1:0] MAX_SPEED = 5'sd10;

	localparam logic [BASE_W-1:0] BASE_RESET = 16'd300;
	localparam logic [DEC_W-1:0]  DEC_RESET  = 13'd20;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_DEC  = 2'd1;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_KEY  = 1'b1;

	localparam logic [KEY_W-1:0] KEY_INC   = 8'h69; // 'i'
	localparam logic [KEY_W-1:0] KEY_DEC   = 8'h64; // 'd'
	localparam logic [KEY_W-1:0] KEY_STOP  = 8'h73; // 's'
	localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h30; // '0'
	localparam logic [KEY_W-1:0] KEY_ONE   = 8'h31;
	localparam logic [KEY_W-1:0] KEY_FIVE  = 8'h35;
	localparam logic [KEY_W-1:0] KEY_SIX   = 8'h36;
	localparam logic [KEY_W-1:0] KEY_NINE  = 8'h39;

	typedef struct packed {
		logic signed [SPEED_W-1:0] speed;
		logic [PHASE_W-1:0]        phase;
		logic [TICK_W-1:0]         tick;
	} sdrv_state_t;

	function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] ph);
		logic [COIL_W-1:0] c;
		case (ph)
			3'd0:    c = 4'd9;
			3'd1:    c = 4'd8;
			3'd2:    c = 4'd12;
			3'd3:    c = 4'd4;
			3'd4:    c = 4'd6;
			3'd5:    c = 4'd2;
			3'd6:    c = 4'd3;
			default: c = 4'd1;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/sdrv_period.sv
// Step period from speed and configuration: base minus |speed| times decrement, floored at one.
`default_nettype none

module sdrv_period
	import sdrv_pkg::*;
(
	input  wire logic signed [SPEED_W-1:0] speed,
	input  wire logic [BASE_W-1:0]         base_period,
	input  wire logic [DEC_W-1:0]          period_dec,
	output logic [BASE_W-1:0]              period
);

	logic [SPEED_W-1:0]     neg_speed;
	logic [MAG_W-1:0]       mag;
	logic [DEC_W+MAG_W-1:0] cut;

	always_comb begin
		neg_speed = -speed;
		mag = speed[SPEED_W-1] ? neg_speed[MAG_W-1:0] : speed[MAG_W-1:0];
		cut = {{MAG_W{1'b0}}, period_dec} * {{DEC_W{1'b0}}, mag};
		if (cut >= {{(DEC_W+MAG_W-BASE_W){1'b0}}, base_period}) begin
			period = BASE_W'(1);
		end else begin
			period = base_period - cut[BASE_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/sdrv_step.sv
// Next-state logic for one item: key decoding with saturation, tick counting and phase stepping.
`default_nettype none

module sdrv_step
	import sdrv_pkg::*;
(
	input  wire logic               cmd,
	input  wire logic [KEY_W-1:0]   key_code,
	input  wire sdrv_state_t        cur,
	input  wire logic [BASE_W-1:0]  period,
	output sdrv_state_t             nxt,
	output logic                    stepped
);

	logic signed [SPEED_W:0] want;
	logic                    key_hit;
	logic [TICK_W:0]         tick_inc;

	always_comb begin
		nxt      = cur;
		stepped  = 1'b0;
		want     = {cur.speed[SPEED_W-1], cur.speed};
		key_hit  = 1'b1;
		tick_inc = {1'b0, cur.tick} + (TICK_W+1)'(1);

		if (cmd == CMD_KEY) begin
			case (key_code) inside
				KEY_INC:             want = {cur.speed[SPEED_W-1], cur.speed} + 6'sd1;
				KEY_DEC:             want = {cur.speed[SPEED_W-1], cur.speed} - 6'sd1;
				KEY_STOP:            want = 6'sd0;
				KEY_ZERO:            want = 6'sd10;
				[KEY_ONE:KEY_FIVE]:  want = $signed({1'b0, key_code[3:0], 1'b0}) - 6'sd12;
				[KEY_SIX:KEY_NINE]:  want = $signed({1'b0, key_code[3:0], 1'b0}) - 6'sd10;
				default:             key_hit = 1'b0;
			endcase
			if (key_hit) begin
				if (want > $signed({MAX_SPEED[SPEED_W-1], MAX_SPEED})) begin
					nxt.speed = MAX_SPEED;
				end else if (want < -$signed({MAX_SPEED[SPEED_W-1], MAX_SPEED})) begin
					nxt.speed = -MAX_SPEED;
				end else begin
					nxt.speed = want[SPEED_W-1:0];
				end
			end
		end else begin
			// The count is kept when a key shortens the period, so compare with >=.
			if (tick_inc >= {1'b0, period}) begin
				nxt.tick = '0;
				stepped  = 1'b1;
				if (cur.speed > 0) begin
					nxt.phase = cur.phase + PHASE_W'(1);
				end else if (cur.speed < 0) begin
					nxt.phase = cur.phase - PHASE_W'(1);
				end
			end else begin
				nxt.tick = tick_inc[TICK_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/stepper_half_step_speed_driver_top.sv
// Top level of the half-step stepper driver: ports, configuration, state and stream registers.
//
//  channel  | direction | fields
//  s_*      | in        | tuser: cmd; tdata: key_code
//  m_*      | out       | tdata: coil_pattern, speed_now, stepped, period_now
//  cfg_*    | in        | cfg_index: register, cfg_data: value
//
// An item is registered on entry and its result is registered in the output register, and one
// item is taken in every cycle while the output is not stalled. The state update and the
// period multiply sit between the input register and the result register.
// A stalled output holds its result and the input register; reset gives base 300,
// decrement 20, speed zero, phase zero and tick count zero.
`default_nettype none

module stepper_half_step_speed_driver_top
	import sdrv_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [KEY_W-1:0]     s_tdata,   // [7:0] key_code
	input  wire logic                 s_tuser,   // [0] cmd
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [OUT_W-1:0]          m_tdata,   // [3:0] coil_pattern, [8:4] speed_now,
	                                             // [9] stepped, [25:10] period_now, rest zero
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BASE_W-1:0]    cfg_data
);

	logic [BASE_W-1:0] base_q;
	logic [DEC_W-1:0]  dec_q;
	sdrv_state_t       state_q;
	sdrv_state_t       state_d;
	logic [BASE_W-1:0] period_q;
	logic [BASE_W-1:0] period_d;
	logic              stepped_d;

	logic              valid_s1;
	logic              cmd_s1;
	logic [KEY_W-1:0]  key_s1;
	logic              advance;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			dec_q  <= DEC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_BASE_PERIOD) begin
				base_q <= cfg_data;
			end else if (cfg_index == REG_PERIOD_DEC) begin
				dec_q <= cfg_data[DEC_W-1:0];
			end
		end
	end

	sdrv_step u_step (
		.cmd      (cmd_s1),
		.key_code (key_s1),
		.cur      (state_q),
		.period   (period_q),
		.nxt      (state_d),
		.stepped  (stepped_d)
	);

	// The period follows the speed the state will hold after this edge, and period_q picks up
	// configuration writes in the cycle after they land.
	sdrv_period u_period (
		.speed       (advance ? state_d.speed : state_q.speed),
		.base_period (base_q),
		.period_dec  (dec_q),
		.period      (period_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			period_q <= BASE_RESET;
		end else begin
			period_q <= period_d;
			if (advance) begin
				state_q <= state_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= s_tuser;
			key_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {6'b0, period_d, stepped_d, state_d.speed, coil_of(state_d.phase)};
		end
	end

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the half-step stepper driver: directed and random requests.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sdrv_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int unsigned DEC_TOP = 6553;
	localparam int KEY_ZERO_SPEED = 10;
	localparam int ITEMS_PER_PHASE = 130;
	// Coil drive per half-step phase, phase 0 in the lowest nibble.
	localparam logic [8*COIL_W-1:0] COIL_LUT =
		{4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9};
	localparam logic [KEY_W-1:0] KEY_SLASH = 8'h2f;
	localparam logic [KEY_W-1:0] KEY_COLON = 8'h3a;
	localparam logic [KEY_W-1:0] KEY_UPPER_I = 8'h49;

	typedef struct packed {
		logic [COIL_W-1:0]         coil;
		logic signed [SPEED_W-1:0] speed;
		logic                      stepped;
		logic [BASE_W-1:0]         period;
	} coil_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [KEY_W-1:0]     s_tdata = '0;   // [7:0] key_code
	logic                 s_tuser = 1'b0; // [0] cmd
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;        // [3:0] coil_pattern, [8:4] speed_now,
	                                      // [9] stepped, [25:10] period_now
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BASE_W-1:0]    cfg_data = '0;

	// Shadow copy of the driver state and its registers.
	logic [BASE_W-1:0]         base_ticks;
	logic [DEC_W-1:0]          dec_ticks;
	logic signed [SPEED_W-1:0] speed_lvl;
	logic [PHASE_W-1:0]        phase;
	logic [TICK_W-1:0]         tick_cnt;

	coil_result_t coil_results_due[$];
	int errors = 0;
	int burst_left = 0;
	int rx_left = 0;
	logic rx_on = 1'b0;

	stepper_half_step_speed_driver_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic logic [BASE_W-1:0] step_period();
		int s;
		int unsigned mag;
		int unsigned cut;
		s = speed_lvl;
		mag = (s < 0) ? -s : s;
		cut = mag * dec_ticks;
		if (cut >= base_ticks)
			return 16'd1;
		return 16'(base_ticks - cut);
	endfunction

	function automatic void apply_key(input logic [KEY_W-1:0] k);
		int s;
		int top;
		s = speed_lvl;
		top = MAX_SPEED;
		if (k == KEY_INC)
			s = s + 1;
		else if (k == KEY_DEC)
			s = s - 1;
		else if (k == KEY_STOP)
			s = 0;
		else if (k == KEY_ZERO)
			s = KEY_ZERO_SPEED;
		else if (k >= KEY_ONE && k <= KEY_FIVE)
			s = (int'(k - KEY_ZERO) - 6) * 2;
		else if (k >= KEY_SIX && k <= KEY_NINE)
			s = (int'(k - KEY_ZERO) - 5) * 2;
		else
			return;
		if (s > top)
			s = top;
		if (s < -top)
			s = -top;
		speed_lvl = 5'(s);
	endfunction

	function automatic coil_result_t predict_coil_step(input logic cmd, input logic [KEY_W-1:0] key);
		coil_result_t r;
		int unsigned per;
		r.stepped = 1'b0;
		if (cmd == CMD_KEY) begin
			apply_key(key);
		end else begin
			per = step_period();
			if (tick_cnt + 1 >= per) begin
				tick_cnt = '0;
				r.stepped = 1'b1;
				if (speed_lvl > 0)
					phase = phase + 3'd1;
				else if (speed_lvl < 0)
					phase = phase - 3'd1;
			end else begin
				tick_cnt = tick_cnt + 16'd1;
			end
		end
		r.coil = COIL_LUT[{phase, 2'b00} +: COIL_W];
		r.speed = speed_lvl;
		r.period = step_period();
		return r;
	endfunction

	// The sender works in bursts; valid only drops when a gap is actually taken.
	task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = $urandom_range(0, 5);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= key;
		do @(posedge clk); while (s_tready !== 1'b1);
		coil_results_due.push_back(predict_coil_step(cmd, key));
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
	endtask

	// Withdraws the sender and waits until every pending request has produced its result.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (coil_results_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BASE_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == REG_BASE_PERIOD)
			base_ticks = value;
		else if (idx == REG_PERIOD_DEC)
			dec_ticks = value[DEC_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_periods(input int unsigned base, input int unsigned dec);
		settle();
		write_reg(REG_BASE_PERIOD, 16'(base));
		write_reg(REG_PERIOD_DEC, 16'(dec));
	endtask

	// Every key class at the reset periods, including saturation at both ends.
	task automatic test_key_map();
		send_ticks(2);
		send_item(CMD_KEY, KEY_ZERO);
		send_item(CMD_KEY, KEY_INC);
		send_item(CMD_TICK, 8'hff);
		send_item(CMD_KEY, KEY_ONE);
		send_item(CMD_KEY, KEY_DEC);
		send_item(CMD_KEY, 8'h32);
		send_item(CMD_KEY, KEY_FIVE);
		send_item(CMD_KEY, KEY_SIX);
		send_item(CMD_KEY, KEY_NINE);
		send_item(CMD_KEY, KEY_STOP);
		send_item(CMD_KEY, KEY_INC);
		send_item(CMD_KEY, KEY_DEC);
		send_item(CMD_KEY, 8'h00);
		send_item(CMD_KEY, 8'hff);
		send_item(CMD_KEY, KEY_SLASH);
		send_item(CMD_KEY, KEY_COLON);
		send_item(CMD_KEY, KEY_UPPER_I);
	endtask

	task automatic test_period_floor();
		// A zero base floors the period at one tick.
		set_periods(0, 0);
		send_item(CMD_KEY, KEY_SIX);
		send_ticks(2);
		// The cut exceeds the base.
		set_periods(50, 25);
		send_item(CMD_KEY, 8'h37);
		send_ticks(1);
		set_periods(65535, DEC_TOP);
		send_item(CMD_KEY, KEY_ZERO);
		send_ticks(5);
		// A key shortens the period down to the count already reached.
		set_periods(6, 1);
		send_item(CMD_KEY, KEY_STOP);
		send_ticks(4);
		send_item(CMD_KEY, KEY_SIX);
		send_ticks(2);
	endtask

	// Writes to indexes with no register behind them must change nothing.
	task automatic test_spare_registers();
		settle();
		write_reg(REG_SPARE_A, 16'($urandom_range(0, 65535)));
		write_reg(REG_SPARE_B, 16'($urandom_range(0, 65535)));
		send_item(CMD_KEY, KEY_DEC);
		send_ticks(3);
	endtask

	task automatic test_random_traffic();
		logic [KEY_W-1:0] key;
		int pick;
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: set_periods($urandom_range(1, 30), $urandom_range(0, 5));
				1: set_periods(65535, DEC_TOP);
				2: set_periods(1, 0);
				3: set_periods($urandom_range(2, 60), $urandom_range(0, 20));
				4: set_periods($urandom_range(1, 65535), $urandom_range(0, DEC_TOP));
				5: set_periods($urandom_range(8, 200), $urandom_range(0, 30));
				default: set_periods(BASE_RESET, DEC_RESET);
			endcase
			if ($urandom_range(0, 1) == 1)
				write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B,
					16'($urandom_range(0, 65535)));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (p == 3 && n == ITEMS_PER_PHASE / 2)
					settle();
				if ($urandom_range(0, 9) < 7) begin
					send_item(CMD_TICK, 8'($urandom_range(0, 255)));
				end else begin
					pick = $urandom_range(0, 9);
					if (pick < 3)
						key = KEY_INC;
					else if (pick < 5)
						key = KEY_DEC;
					else if (pick == 5)
						key = KEY_STOP;
					else if (pick < 9)
						key = KEY_ZERO + 8'($urandom_range(0, 9));
					else
						key = 8'($urandom_range(0, 255));
					send_item(CMD_KEY, key);
				end
			end
		end
	endtask

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_on = ~rx_on;
			if (rx_on)
				rx_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
					: $urandom_range(1, 10);
			else
				rx_left = $urandom_range(1, 6);
		end
		rx_left--;
		m_tready <= rx_on;
	end

	always @(posedge clk) begin : check_result
		coil_result_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (coil_results_due.size() == 0) begin
				$error("result with no request pending: m_tdata %h", m_tdata);
				errors++;
			end else begin
				want = coil_results_due.pop_front();
				if (m_tdata[3:0] !== want.coil) begin
					$error("coil_pattern expected %0d got %0d", want.coil, m_tdata[3:0]);
					errors++;
				end
				if (m_tdata[8:4] !== want.speed) begin
					$error("speed_now expected %0d got %0d", want.speed, $signed(m_tdata[8:4]));
					errors++;
				end
				if (m_tdata[9] !== want.stepped) begin
					$error("stepped expected %0d got %0d", want.stepped, m_tdata[9]);
					errors++;
				end
				if (m_tdata[25:10] !== want.period) begin
					$error("period_now expected %0d got %0d", want.period, m_tdata[25:10]);
					errors++;
				end
				if (m_tdata[31:26] !== 6'd0) begin
					$error("padding expected 0 got %0d", m_tdata[31:26]);
					errors++;
				end
			end
		end
	end

	initial begin
		base_ticks = BASE_RESET;
		dec_ticks = DEC_RESET;
		speed_lvl = '0;
		phase = '0;
		tick_cnt = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		test_key_map();
		test_period_floor();
		test_spare_registers();
		test_random_traffic();
		settle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: files.f
rtl/core/sdrv_pkg.sv
rtl/core/sdrv_period.sv
rtl/core/sdrv_step.sv
rtl/core/stepper_half_step_speed_driver_top.sv
sim/tb.sv
